FILE: sv/chunk_maze_generator_defines.svh
// assertion macros for the chunk maze generator
// no dependencies
`ifndef CHUNK_MAZE_GENERATOR_DEFINES_SVH
`define CHUNK_MAZE_GENERATOR_DEFINES_SVH
`define CMG_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("check failed");
`define CMG_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("check failed");
`endif

FILE: sv/cmg_pkg.sv
// shared types and constants for the chunk maze generator
// no dependencies
package cmg_pkg;
  localparam int unsigned GridSizeDef = 21;
  localparam int unsigned GatePosDef  = 10;
  localparam logic [31:0] LcgMul  = 32'd1664525;
  localparam logic [31:0] LcgAdd  = 32'd1013904223;
  localparam logic [31:0] YMul    = 32'd22695477;
  localparam logic [31:0] SeedMul = 32'd2654435761;

  typedef struct packed {
    logic signed [31:0] chunk_x;
    logic signed [31:0] chunk_y;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  row_index;
    logic [20:0] row_bits;
    logic        last_row;
  } out_beat_t;

  typedef enum logic [3:0] {
    StIdle, StSeedX, StSeedY, StSeedMix, StFill, StPush,
    StDraw, StTry, StOut
  } state_e;

  typedef enum logic [1:0] {
    MulLcg, MulX, MulY, MulSeed
  } mul_op_e;

  typedef enum logic [1:0] {
    DirUp = 2'd0, DirDown = 2'd1, DirLeft = 2'd2, DirRight = 2'd3
  } dir_e;
endpackage

FILE: sv/cmg_ram.sv
// generic single-port ram with registered read
// no dependencies
module cmg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: sv/cmg_mac.sv
// shared 32-bit multiply-add unit, one registered product per cycle
// depends on cmg_pkg
module cmg_mac import cmg_pkg::*; (
  input  logic        clk_i,
  input  mul_op_e     op_i,
  input  logic [31:0] a_i,
  output logic [31:0] p_o
);
  logic [31:0] m_d;
  always_comb begin
    unique case (op_i)
      MulLcg:  m_d = a_i * LcgMul + LcgAdd;
      MulX:    m_d = a_i * LcgMul + LcgAdd;
      MulY:    m_d = a_i * YMul + 32'd1;
      MulSeed: m_d = a_i * SeedMul;
      default: m_d = '0;
    endcase
  end
  always_ff @(posedge clk_i) begin
    p_o <= m_d;
  end
endmodule

FILE: sv/chunk_maze_generator.sv
// chunk maze generator: sequencer, shared multiply-add unit, grid register rows
// and stack ram; depends on cmg_pkg, cmg_mac, cmg_ram, defines header
// sequence: seed from chunk x, chunk y and world seed, fill the grid rows, then
// carve passes that each draw a direction order and probe the tried directions,
// a pop adding a stack read; then the grid goes out as row beats, each held until taken
// one chunk at a time; async active-low reset clears control and world seed
// grid and stack contents need no reset, each chunk rewrites them before use
`include "chunk_maze_generator_defines.svh"
module chunk_maze_generator import cmg_pkg::*; #(
  parameter int unsigned GridSize = GridSizeDef,
  parameter int unsigned GatePos  = GatePosDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);
  localparam int unsigned Cells  = (GridSize - 1) / 2;
  localparam int unsigned Depth  = Cells * Cells + 1;
  localparam int unsigned SpW    = $clog2(Depth + 1);
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned CW     = $clog2(GridSize);
  localparam int unsigned RW     = $clog2(GridSize + 1);

  state_e st_q, st_d;
  logic [31:0] seed_q, seed_d, acc_q, acc_d;
  logic [31:0] mac_a, mac_p;
  mul_op_e     mac_op;
  logic [GridSize-1:0] grid_q [GridSize];
  logic [GridSize-1:0] grid_d [GridSize];
  logic [SpW-1:0] sp_q, sp_d;
  logic [1:0] ord_q [4];
  logic [1:0] ord_d [4];
  logic [1:0] di_q, di_d;
  logic [2:0] k_q, k_d;
  logic [CW-1:0] x_q, x_d, y_q, y_d;
  logic [RW-1:0] row_q, row_d;
  logic          mv_q, mv_d;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [2*CW-1:0] ram_wd, ram_rd;
  logic          fill_q, fill_d;
  out_beat_t     ob_q, ob_d;
  logic          ov_q, ov_d;

  cmg_mac u_mac (.clk_i(clk_i), .op_i(mac_op), .a_i(mac_a), .p_o(mac_p));

  cmg_ram #(.Width(2*CW), .Depth(Depth)) u_stack (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; seed_q <= '0; sp_q <= '0; ov_q <= 1'b0;
      k_q <= '0; di_q <= '0; row_q <= '0; mv_q <= 1'b0; fill_q <= 1'b0;
    end else begin
      st_q <= st_d; seed_q <= seed_d; sp_q <= sp_d; ov_q <= ov_d;
      k_q <= k_d; di_q <= di_d; row_q <= row_d; mv_q <= mv_d; fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; grid_q <= grid_d; ord_q <= ord_d;
    x_q <= x_d; y_q <= y_d; ob_q <= ob_d;
  end

  logic [CW:0] nx, ny;
  logic [CW:0] mx, my;
  logic [1:0]  dsel;
  logic [31:0] dmod;
  logic        ok;

  always_comb begin
    st_d = st_q; seed_d = seed_q; acc_d = acc_q; grid_d = grid_q; sp_d = sp_q;
    ord_d = ord_q; di_d = di_q; k_d = k_q; x_d = x_q; y_d = y_q; row_d = row_q;
    mv_d = mv_q; fill_d = fill_q; ob_d = ob_q; ov_d = ov_q;
    mac_op = MulLcg; mac_a = acc_q;
    ram_we = 1'b0; ram_addr = AW'(sp_q - SpW'(1)); ram_wd = {y_q, x_q};
    in_ready_o = 1'b0; cfg_ready_o = (st_q == StIdle) && !ov_q;
    dsel = ord_q[k_q[1:0]];
    nx = {1'b0, x_q}; ny = {1'b0, y_q};
    dmod = '0; ok = 1'b0;
    unique case (dir_e'(dsel))
      DirUp:    ny = {1'b0, y_q} - (CW+1)'(2);
      DirDown:  ny = {1'b0, y_q} + (CW+1)'(2);
      DirLeft:  nx = {1'b0, x_q} - (CW+1)'(2);
      DirRight: nx = {1'b0, x_q} + (CW+1)'(2);
      default: ;
    endcase
    mx = ({1'b0, x_q} + nx) >> 1;
    my = ({1'b0, y_q} + ny) >> 1;
    if (out_ready_i) ov_d = 1'b0;
    if (cfg_valid_i && cfg_ready_o) seed_d = cfg_data_i;
    unique case (st_q)
      StIdle: begin
        in_ready_o = !ov_q;
        mac_op = MulX; mac_a = in_data_i.chunk_x;
        if (in_valid_i && !ov_q) begin
          acc_d = in_data_i.chunk_y;
          st_d = StSeedX;
        end
      end
      StSeedX: begin
        mac_op = MulY; mac_a = acc_q;
        acc_d = seed_q ^ mac_p;
        st_d = StSeedY;
      end
      StSeedY: begin
        acc_d = acc_q ^ mac_p;
        st_d = StSeedMix;
      end
      StSeedMix: begin
        mac_op = MulSeed; mac_a = acc_q;
        row_d = '0;
        st_d = StFill;
      end
      StFill: begin
        if (!fill_q) begin
          acc_d = mac_p; fill_d = 1'b1;
        end
        grid_d[row_q[CW-1:0]] = '1;
        if (row_q == RW'(GridSize - 1)) begin
          fill_d = 1'b0;
          st_d = StPush;
        end else begin
          row_d = row_q + RW'(1);
        end
      end
      StPush: begin
        grid_d[GatePos][0] = 1'b0;
        grid_d[GatePos][GridSize-1] = 1'b0;
        grid_d[0][GatePos] = 1'b0;
        grid_d[GridSize-1][GatePos] = 1'b0;
        grid_d[1][1] = 1'b0;
        x_d = CW'(1); y_d = CW'(1);
        ram_we = 1'b1; ram_addr = '0; ram_wd = {CW'(1), CW'(1)};
        sp_d = SpW'(1);
        di_d = 2'd3; k_d = '0;
        for (int i = 0; i < 4; i++) ord_d[i] = 2'(i);
        st_d = StDraw;
      end
      StDraw: begin
        // one lcg draw a cycle, product registered, swap next cycle
        if (k_q == 3'd0) begin
          mac_a = acc_q;
          k_d = 3'd1;
        end else begin
          unique case (di_q)
            2'd3:    dmod = {30'd0, mac_p[1:0]};
            2'd2:    dmod = mac_p - 32'((64'(mac_p) * 64'd2863311531) >> 33) * 32'd3;
            default: dmod = {31'd0, mac_p[0]};
          endcase
          ord_d[di_q] = ord_q[dmod[1:0]];
          ord_d[dmod[1:0]] = ord_q[di_q];
          acc_d = mac_p;
          mac_a = mac_p;
          if (di_q == 2'd1) begin
            k_d = '0; st_d = StTry;
          end else begin
            di_d = di_q - 2'd1;
          end
        end
      end
      StTry: begin
        ok = (nx >= (CW+1)'(1)) && (nx < (CW+1)'(GridSize - 1)) &&
             (ny >= (CW+1)'(1)) && (ny < (CW+1)'(GridSize - 1));
        if (ok) ok = grid_q[ny[CW-1:0]][nx[CW-1:0]];
        if (ok) begin
          grid_d[ny[CW-1:0]][nx[CW-1:0]] = 1'b0;
          grid_d[my[CW-1:0]][mx[CW-1:0]] = 1'b0;
          ram_we = (sp_q < SpW'(Depth));
          ram_addr = AW'(sp_q);
          ram_wd = {ny[CW-1:0], nx[CW-1:0]};
          if (ram_we) begin
            sp_d = sp_q + SpW'(1);
            x_d = nx[CW-1:0]; y_d = ny[CW-1:0];
          end
          di_d = 2'd3; k_d = '0;
          for (int i = 0; i < 4; i++) ord_d[i] = 2'(i);
          st_d = StDraw;
        end else if (k_q == 3'd3) begin
          sp_d = sp_q - SpW'(1);
          mv_d = 1'b1;
          ram_addr = AW'(sp_q - SpW'(2));
          k_d = 3'd4;
          st_d = StOut;
          if (sp_q == SpW'(1)) row_d = '0;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      StOut: begin
        if (mv_q) begin
          // pop: wait for stack read, then continue or emit
          if (sp_q == '0) begin
            mv_d = 1'b0;
          end else begin
            mv_d = 1'b0;
            {y_d, x_d} = ram_rd;
            di_d = 2'd3; k_d = '0;
            for (int i = 0; i < 4; i++) ord_d[i] = 2'(i);
            st_d = StDraw;
          end
        end else if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          ob_d.row_index = 5'(row_q);
          ob_d.row_bits = 21'(grid_q[row_q[CW-1:0]]);
          ob_d.last_row = (row_q == RW'(GridSize - 1));
          if (row_q == RW'(GridSize - 1)) st_d = StIdle;
          else row_d = row_q + RW'(1);
        end
      end
      default: st_d = StIdle;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = ob_q;

  `CMG_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, st_q != StIdle, !in_ready_o)
  `CMG_ASSERT_IMP(a_sp_bound, clk_i, rst_ni, 1'b1, sp_q <= SpW'(Depth))
  `CMG_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, in_valid_i && in_ready_o, st_q == StSeedX)
endmodule
